FILE: src/rust_token_scanner_defines.svh
// assertion macros shared by the token scanner modules
// depends on nothing; included by files that carry assertions
`ifndef RUST_TOKEN_SCANNER_DEFINES_SVH
`define RUST_TOKEN_SCANNER_DEFINES_SVH

// antecedent holds -> consequent in the same cycle
`define RTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rts check failed");

// antecedent holds -> consequent in the next cycle
`define RTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rts check failed");

`endif

FILE: src/rts_pkg.sv
// shared types and constants of the token scanner
// depends on nothing
package rts_pkg;

    localparam int unsigned FifoDepth = 4;
    localparam int unsigned FifoAw    = $clog2(FifoDepth);

    typedef struct packed {
        logic        start_req;
        logic        allow_string_content;
        logic        allow_raw_string;
        logic        allow_float;
        logic [20:0] code_point;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  token_kind;
        logic [15:0] skipped;
        logic [15:0] token_length;
    } t_result;

    typedef enum logic [4:0] {
        CLS_NUL, CLS_SPACE, CLS_DQUOTE, CLS_BSLASH, CLS_HASH, CLS_UNDER, CLS_DOT,
        CLS_E, CLS_STAR, CLS_SLASH, CLS_U, CLS_I, CLS_F, CLS_R, CLS_B,
        CLS_DIGIT, CLS_SIGN, CLS_ALPHA, CLS_OTHER
    } t_cls;

    typedef struct packed {
        logic       start;
        logic [2:0] flags;  // float, raw, string content
        t_cls       cls;
    } t_token;

    typedef enum logic [4:0] {
        PH_IDLE, PH_STR, PH_WS, PH_RAW_R, PH_RAW_OPEN, PH_RAW_BODY, PH_RAW_CLOSE,
        PH_F_INT, PH_F_DOT, PH_F_FRAC, PH_F_EXP, PH_F_SIGN, PH_F_EXP_FIRST,
        PH_F_EXP_DIG, PH_F_SUF, PH_F_SUF_FIRST, PH_F_SUF_DIG,
        PH_C_OPEN, PH_C_BODY, PH_C_SLASH
    } t_phase;

    typedef enum logic [1:0] {ST_FOUND = 2'd0, ST_NONE = 2'd1, ST_OVF = 2'd2} t_status;
    typedef enum logic [1:0] {
        KIND_STR = 2'd0, KIND_RAW = 2'd1, KIND_FLOAT = 2'd2, KIND_COMMENT = 2'd3
    } t_kind;

    localparam logic [15:0] MaxLen    = 16'hFFFF;
    localparam logic [7:0]  MaxNest   = 8'hFF;
    localparam logic [7:0]  MaxHashes = 8'hFF;

endpackage

FILE: src/rts_classify.sv
// front end: turns one code point and its flags into a narrow token
// depends on rts_pkg
module rts_classify (
    input  rts_pkg::t_in_item i_item,
    output rts_pkg::t_token   o_token
);
    logic [20:0] c;
    rts_pkg::t_cls cls;

    assign c = i_item.code_point;

    always_comb begin
        priority if (c == 21'd0)                          cls = rts_pkg::CLS_NUL;
        else if (c == 21'd32 || (c >= 21'd9 && c <= 21'd13)) cls = rts_pkg::CLS_SPACE;
        else if (c == 21'd34)                             cls = rts_pkg::CLS_DQUOTE;
        else if (c == 21'd92)                             cls = rts_pkg::CLS_BSLASH;
        else if (c == 21'd35)                             cls = rts_pkg::CLS_HASH;
        else if (c == 21'd95)                             cls = rts_pkg::CLS_UNDER;
        else if (c == 21'd46)                             cls = rts_pkg::CLS_DOT;
        else if (c == 21'd101 || c == 21'd69)             cls = rts_pkg::CLS_E;
        else if (c == 21'd42)                             cls = rts_pkg::CLS_STAR;
        else if (c == 21'd47)                             cls = rts_pkg::CLS_SLASH;
        else if (c == 21'd117)                            cls = rts_pkg::CLS_U;
        else if (c == 21'd105)                            cls = rts_pkg::CLS_I;
        else if (c == 21'd102)                            cls = rts_pkg::CLS_F;
        else if (c == 21'd114)                            cls = rts_pkg::CLS_R;
        else if (c == 21'd98)                             cls = rts_pkg::CLS_B;
        else if (c >= 21'd48 && c <= 21'd57)              cls = rts_pkg::CLS_DIGIT;
        else if (c == 21'd43 || c == 21'd45)              cls = rts_pkg::CLS_SIGN;
        else if ((c >= 21'd97 && c <= 21'd122) || (c >= 21'd65 && c <= 21'd90))
                                                          cls = rts_pkg::CLS_ALPHA;
        else                                              cls = rts_pkg::CLS_OTHER;
    end

    assign o_token.start = i_item.start_req;
    assign o_token.flags = {i_item.allow_float, i_item.allow_raw_string,
                            i_item.allow_string_content};
    assign o_token.cls   = cls;
endmodule

FILE: src/rts_fifo.sv
// short token queue between classifier and scan engine
// depends on rts_pkg
module rts_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rts_pkg::t_token i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output rts_pkg::t_token o_data
);
    rts_pkg::t_token r_mem [rts_pkg::FifoDepth];
    logic [rts_pkg::FifoAw-1:0] r_wr, r_rd;
    logic [rts_pkg::FifoAw:0]   r_cnt, n_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (rts_pkg::FifoAw+1)'(rts_pkg::FifoDepth));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) n_cnt = r_cnt + 1'b1;
        else if (do_pop && !do_push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= n_cnt;
        end
    end
endmodule

FILE: src/rts_engine.sv
// back end: scan state machine, one token per cycle while the result register can take a result, with result register
// depends on rts_pkg and rust_token_scanner_defines.svh
`include "rust_token_scanner_defines.svh"
module rts_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    input  rts_pkg::t_token  i_tok,
    output logic             o_tok_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output rts_pkg::t_result o_result
);
    rts_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_flags, n_flags;
    logic [7:0]  r_open, n_open, r_close, n_close, r_nest, n_nest;
    logic        r_star, n_star, r_frac, n_frac, r_expo, n_expo, r_content, n_content;
    logic [15:0] r_cons, n_cons, r_mark, n_mark, r_skip, n_skip;
    logic        r_out_valid;
    rts_pkg::t_result r_out, res;

    logic        fire, em, ov, done;
    rts_pkg::t_status est;
    rts_pkg::t_kind   ekind;
    logic [15:0] elen;
    rts_pkg::t_cls cls;
    logic fdig, alpha;

    assign o_tok_pop = i_tok_valid && (!r_out_valid || i_ready);
    assign fire      = o_tok_pop;
    assign cls       = i_tok.cls;
    assign fdig      = (cls == rts_pkg::CLS_DIGIT) || (cls == rts_pkg::CLS_UNDER);
    assign alpha     = (cls == rts_pkg::CLS_ALPHA) || (cls == rts_pkg::CLS_E) ||
                       (cls == rts_pkg::CLS_U) || (cls == rts_pkg::CLS_I) ||
                       (cls == rts_pkg::CLS_F) || (cls == rts_pkg::CLS_R) ||
                       (cls == rts_pkg::CLS_B);

    // next state: one scan step, with up to four chained phase evaluations
    always_comb begin
        n_phase = r_phase; n_flags = r_flags; n_open = r_open; n_close = r_close;
        n_nest = r_nest; n_star = r_star; n_frac = r_frac; n_expo = r_expo;
        n_content = r_content; n_cons = r_cons; n_mark = r_mark; n_skip = r_skip;
        em = 1'b0; ov = 1'b0; done = 1'b0;
        est = rts_pkg::ST_NONE; ekind = rts_pkg::KIND_STR; elen = '0;
        if (i_tok.start) begin
            n_flags = i_tok.flags;
            n_open = '0; n_close = '0; n_nest = '0; n_star = 1'b0; n_frac = 1'b0;
            n_expo = 1'b0; n_content = 1'b0; n_cons = '0; n_mark = '0; n_skip = '0;
            n_phase = (i_tok.flags[0] && !i_tok.flags[2]) ? rts_pkg::PH_STR
                                                          : rts_pkg::PH_WS;
        end
        for (int k = 0; k < 4; k++) begin
            if (!done) begin
                done = 1'b1;
                unique case (n_phase)
                    rts_pkg::PH_STR: begin
                        if (cls == rts_pkg::CLS_DQUOTE || cls == rts_pkg::CLS_BSLASH) begin
                            em = 1'b1;
                            if (n_content) begin
                                est = rts_pkg::ST_FOUND; ekind = rts_pkg::KIND_STR;
                                elen = n_cons;
                            end
                        end else if (cls == rts_pkg::CLS_NUL) begin
                            em = 1'b1;
                        end else begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            n_content = 1'b1;
                        end
                    end
                    rts_pkg::PH_WS: begin
                        if (cls == rts_pkg::CLS_SPACE) begin
                            if (n_skip == rts_pkg::MaxLen) ov = 1'b1;
                            else n_skip = n_skip + 1'b1;
                        end else if (n_flags[1] && (cls == rts_pkg::CLS_R ||
                                                    cls == rts_pkg::CLS_B)) begin
                            n_phase = rts_pkg::PH_RAW_R;
                            if (cls == rts_pkg::CLS_B) begin
                                if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                                n_cons = n_cons + 1'b1;
                            end else begin
                                done = 1'b0;
                            end
                        end else if (n_flags[2] && cls == rts_pkg::CLS_DIGIT) begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            n_phase = rts_pkg::PH_F_INT;
                        end else begin
                            n_phase = rts_pkg::PH_C_OPEN;
                            if (cls == rts_pkg::CLS_SLASH) begin
                                if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                                n_cons = n_cons + 1'b1;
                            end else begin
                                done = 1'b0;
                            end
                        end
                    end
                    rts_pkg::PH_RAW_R: begin
                        if (cls != rts_pkg::CLS_R) em = 1'b1;
                        else begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            n_phase = rts_pkg::PH_RAW_OPEN;
                        end
                    end
                    rts_pkg::PH_RAW_OPEN: begin
                        if (cls == rts_pkg::CLS_HASH) begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            if (n_open == rts_pkg::MaxHashes) ov = 1'b1;
                            n_open = n_open + 1'b1;
                        end else if (cls != rts_pkg::CLS_DQUOTE) begin
                            em = 1'b1;
                        end else begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            n_phase = rts_pkg::PH_RAW_BODY;
                        end
                    end
                    rts_pkg::PH_RAW_BODY: begin
                        if (cls == rts_pkg::CLS_NUL) em = 1'b1;
                        else begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            if (cls == rts_pkg::CLS_DQUOTE) begin
                                n_close = '0;
                                if (n_open == '0) begin
                                    em = 1'b1; est = rts_pkg::ST_FOUND;
                                    ekind = rts_pkg::KIND_RAW; elen = n_cons;
                                end else begin
                                    n_phase = rts_pkg::PH_RAW_CLOSE;
                                end
                            end
                        end
                    end
                    rts_pkg::PH_RAW_CLOSE: begin
                        if (cls == rts_pkg::CLS_HASH && n_close < n_open) begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            n_close = n_close + 1'b1;
                            if (n_close == n_open) begin
                                em = 1'b1; est = rts_pkg::ST_FOUND;
                                ekind = rts_pkg::KIND_RAW; elen = n_cons;
                            end
                        end else begin
                            n_phase = rts_pkg::PH_RAW_BODY;
                            done = 1'b0;
                        end
                    end
                    rts_pkg::PH_F_INT, rts_pkg::PH_F_FRAC: begin
                        if (fdig) begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                        end else if (n_phase == rts_pkg::PH_F_INT &&
                                     cls == rts_pkg::CLS_DOT) begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            n_frac = 1'b1;
                            n_phase = rts_pkg::PH_F_DOT;
                        end else begin
                            n_mark = n_cons;
                            n_phase = rts_pkg::PH_F_EXP;
                            done = 1'b0;
                        end
                    end
                    rts_pkg::PH_F_DOT: begin
                        if (alpha || cls == rts_pkg::CLS_DOT) em = 1'b1;
                        else begin
                            n_phase = rts_pkg::PH_F_FRAC;
                            done = 1'b0;
                        end
                    end
                    rts_pkg::PH_F_EXP: begin
                        if (cls == rts_pkg::CLS_E) begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            n_expo = 1'b1;
                            n_phase = rts_pkg::PH_F_SIGN;
                        end else begin
                            n_phase = rts_pkg::PH_F_SUF;
                            done = 1'b0;
                        end
                    end
                    rts_pkg::PH_F_SIGN: begin
                        n_phase = rts_pkg::PH_F_EXP_FIRST;
                        if (cls == rts_pkg::CLS_SIGN) begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                        end else begin
                            done = 1'b0;
                        end
                    end
                    rts_pkg::PH_F_EXP_FIRST: begin
                        if (!fdig) begin
                            em = 1'b1; est = rts_pkg::ST_FOUND;
                            ekind = rts_pkg::KIND_FLOAT; elen = n_mark;
                        end else begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            n_phase = rts_pkg::PH_F_EXP_DIG;
                        end
                    end
                    rts_pkg::PH_F_EXP_DIG: begin
                        if (fdig) begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                        end else begin
                            n_mark = n_cons;
                            n_phase = rts_pkg::PH_F_SUF;
                            done = 1'b0;
                        end
                    end
                    rts_pkg::PH_F_SUF: begin
                        if (!n_expo && !n_frac) begin
                            em = 1'b1;
                        end else if (cls != rts_pkg::CLS_U && cls != rts_pkg::CLS_I &&
                                     cls != rts_pkg::CLS_F) begin
                            em = 1'b1; est = rts_pkg::ST_FOUND;
                            ekind = rts_pkg::KIND_FLOAT; elen = n_mark;
                        end else begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            n_phase = rts_pkg::PH_F_SUF_FIRST;
                        end
                    end
                    rts_pkg::PH_F_SUF_FIRST, rts_pkg::PH_F_SUF_DIG: begin
                        if (cls == rts_pkg::CLS_DIGIT) begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            n_phase = rts_pkg::PH_F_SUF_DIG;
                        end else begin
                            if (n_phase == rts_pkg::PH_F_SUF_DIG) n_mark = n_cons;
                            em = 1'b1; est = rts_pkg::ST_FOUND;
                            ekind = rts_pkg::KIND_FLOAT; elen = n_mark;
                        end
                    end
                    rts_pkg::PH_C_OPEN: begin
                        if (cls != rts_pkg::CLS_STAR) em = 1'b1;
                        else begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            n_nest = 8'd1;
                            n_star = 1'b0;
                            n_phase = rts_pkg::PH_C_BODY;
                        end
                    end
                    rts_pkg::PH_C_BODY: begin
                        if (cls == rts_pkg::CLS_NUL) em = 1'b1;
                        else begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            if (cls == rts_pkg::CLS_STAR) n_star = 1'b1;
                            else if (cls == rts_pkg::CLS_SLASH) begin
                                if (n_star) begin
                                    n_star = 1'b0;
                                    n_nest = n_nest - 1'b1;
                                    if (n_nest == '0) begin
                                        em = 1'b1; est = rts_pkg::ST_FOUND;
                                        ekind = rts_pkg::KIND_COMMENT; elen = n_cons;
                                    end
                                end else begin
                                    n_phase = rts_pkg::PH_C_SLASH;
                                end
                            end else n_star = 1'b0;
                        end
                    end
                    rts_pkg::PH_C_SLASH: begin
                        n_phase = rts_pkg::PH_C_BODY;
                        if (cls == rts_pkg::CLS_STAR) begin
                            if (n_cons == rts_pkg::MaxLen) ov = 1'b1;
                            n_cons = n_cons + 1'b1;
                            if (n_nest == rts_pkg::MaxNest) ov = 1'b1;
                            n_nest = n_nest + 1'b1;
                        end else begin
                            done = 1'b0;
                        end
                    end
                    default: begin
                        n_phase = rts_pkg::PH_IDLE;
                    end
                endcase
            end
        end
        if (ov) begin
            em = 1'b1; est = rts_pkg::ST_OVF; ekind = rts_pkg::KIND_STR; elen = '0;
        end
        if (em) n_phase = rts_pkg::PH_IDLE;
    end

    // outputs: result payload of this step
    always_comb begin
        res.status       = est;
        res.token_kind   = ekind;
        res.skipped      = n_skip;
        res.token_length = elen;
    end

    always_ff @(posedge i_clk) begin
        if (fire && em) r_out <= res;
        if (fire) begin
            r_flags <= n_flags; r_open <= n_open; r_close <= n_close; r_nest <= n_nest;
            r_star <= n_star; r_frac <= n_frac; r_expo <= n_expo; r_content <= n_content;
            r_cons <= n_cons; r_mark <= n_mark; r_skip <= n_skip;
        end
        if (!i_rst_n) begin
            r_phase     <= rts_pkg::PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) r_phase <= n_phase;
            if (fire && em) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `RTS_ASSERT_NEXT(a_emit_idle, i_clk, i_rst_n, fire && em, r_phase == rts_pkg::PH_IDLE)
    `RTS_ASSERT_NOW(a_miss_clear, i_clk, i_rst_n, o_valid && o_result.status != rts_pkg::ST_FOUND, o_result.token_kind == rts_pkg::KIND_STR && o_result.token_length == '0)
    `RTS_ASSERT_NOW(a_no_pop_blocked, i_clk, i_rst_n, o_valid && !i_ready, !o_tok_pop)
endmodule

FILE: src/rust_token_scanner.sv
// top level of the streaming token scanner
// depends on rts_pkg, rts_classify, rts_fifo, rts_engine
//
// Scans one code point per transaction. A transaction with start_req set begins a
// scan (abandoning any scan in progress) and latches the three allow flags. The
// scanner recognises string content, raw strings, floats and nested block
// comments, and delivers at most one result transaction per input transaction:
// status, kind, skipped whitespace and token length. Throughput is one code point
// per clock unless the queue is full or a result waits in the output register:
// the classifier maps each code point to a short class code, a four-entry queue
// holds classified transactions, and the scan engine performs one complete state
// step per cycle while its output register can take a result. The input side stalls
// only when the queue is full; results pass the queue, then the output register.
module rust_token_scanner (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rts_pkg::t_in_item i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rts_pkg::t_result o_out_result
);
    rts_pkg::t_token cls_tok, q_tok;
    logic q_full, q_valid, q_pop;

    // front: classify the code point
    rts_classify u_cls (
        .i_item  (i_in_item),
        .o_token (cls_tok)
    );

    // queue decouples acceptance from the scan engine
    rts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (cls_tok),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_tok)
    );

    assign o_in_ready = !q_full;

    // back: scan state machine and result register
    rts_engine u_eng (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_tok_pop   (q_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_result    (o_out_result)
    );
endmodule
